// ===== design/selective_repeat_sender_window_unit_macros.svh =====
// ----------------------------------------------------------------------------
// selective repeat sender window - assertion macros
// shared property forms for the port checker, sampled on clk with reset off
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SRSW_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SRSW_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg
// types and codes shared by the selective repeat sender window unit
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int SEQ_W     = 6;
    localparam int FRAME_W   = 16;
    localparam int WIN_CFG_W = 5;
    localparam int CFG_IDX_W = 2;

    // item opcodes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 2'd1;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [SEQ_W-1:0] ack_seq;
    } srsw_in_t;

    typedef struct packed {
        logic               has_frame;
        logic [SEQ_W-1:0]   send_seq;
        logic [FRAME_W-1:0] send_frame;
        logic               last;
        logic               done_res;
    } srsw_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_START,
        ST_ACK,
        ST_POP,
        ST_REFILL,
        ST_SCAN,
        ST_RESEND,
        ST_EMPTY
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD_START,
        CMD_LOAD_REFILL,
        CMD_HEAD_ACK,
        CMD_POP,
        CMD_MARK,
        CMD_RESEND,
        CMD_EMPTY
    } cmd_op_t;

    typedef struct packed {
        logic    capture;
        cmd_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic occ_zero;
        logic head_match;
        logic head_acked;
        logic start_more;
        logic start_last;
        logic refill_more;
        logic refill_last;
        logic walk_last;
    } dp_status_t;

endpackage

// ===== design/srsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// srsw_ctrl
// sequencer: walks one item through load, ack, pop, refill, scan or resend steps
// ----------------------------------------------------------------------------
module srsw_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             opcode,
    input  srsw_pkg::dp_status_t   status,
    output srsw_pkg::dp_cmd_t      cmd,
    output logic                   busy
);

    srsw_pkg::state_t state_reg;
    srsw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srsw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.op      = srsw_pkg::CMD_NONE;
        case (state_reg)
            srsw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (opcode)
                        srsw_pkg::OP_START:
                        begin
                            cmd.op     = srsw_pkg::CMD_CLEAR;
                            state_next = srsw_pkg::ST_LOAD_START;
                        end
                        srsw_pkg::OP_ACK:     state_next = srsw_pkg::ST_ACK;
                        srsw_pkg::OP_TIMEOUT: state_next = srsw_pkg::ST_RESEND;
                        default:              state_next = srsw_pkg::ST_EMPTY;
                    endcase
                end
            end
            srsw_pkg::ST_LOAD_START:
            begin
                if (status.start_more)
                begin
                    cmd.op = srsw_pkg::CMD_LOAD_START;
                    if (status.start_last)
                    begin
                        state_next = srsw_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.op     = srsw_pkg::CMD_EMPTY;
                    state_next = srsw_pkg::ST_IDLE;
                end
            end
            srsw_pkg::ST_ACK:
            begin
                if (status.occ_zero)
                begin
                    cmd.op     = srsw_pkg::CMD_EMPTY;
                    state_next = srsw_pkg::ST_IDLE;
                end
                else if (status.head_match)
                begin
                    cmd.op     = srsw_pkg::CMD_HEAD_ACK;
                    state_next = srsw_pkg::ST_POP;
                end
                else
                begin
                    state_next = srsw_pkg::ST_SCAN;
                end
            end
            srsw_pkg::ST_POP:
            begin
                // pop the run of acked frames at the front, one a cycle
                if (!status.occ_zero && status.head_acked)
                begin
                    cmd.op = srsw_pkg::CMD_POP;
                end
                else
                begin
                    state_next = srsw_pkg::ST_REFILL;
                end
            end
            srsw_pkg::ST_REFILL:
            begin
                if (status.refill_more)
                begin
                    cmd.op = srsw_pkg::CMD_LOAD_REFILL;
                    if (status.refill_last)
                    begin
                        state_next = srsw_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.op     = srsw_pkg::CMD_EMPTY;
                    state_next = srsw_pkg::ST_IDLE;
                end
            end
            srsw_pkg::ST_SCAN:
            begin
                cmd.op = srsw_pkg::CMD_MARK;
                if (status.walk_last)
                begin
                    state_next = srsw_pkg::ST_EMPTY;
                end
            end
            srsw_pkg::ST_RESEND:
            begin
                if (status.occ_zero)
                begin
                    cmd.op     = srsw_pkg::CMD_EMPTY;
                    state_next = srsw_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.op = srsw_pkg::CMD_RESEND;
                    if (status.walk_last)
                    begin
                        state_next = srsw_pkg::ST_IDLE;
                    end
                end
            end
            srsw_pkg::ST_EMPTY:
            begin
                cmd.op     = srsw_pkg::CMD_EMPTY;
                state_next = srsw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = srsw_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != srsw_pkg::ST_IDLE);

endmodule

// ===== design/srsw_datapath.sv =====
// ----------------------------------------------------------------------------
// srsw_datapath
// window slots, counters, configuration registers and the result register
// ----------------------------------------------------------------------------
module srsw_datapath #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [srsw_pkg::FRAME_W-1:0]           cfg_data,
    input  logic [srsw_pkg::SEQ_W-1:0]             ack_seq,
    input  srsw_pkg::dp_cmd_t                      cmd,
    output srsw_pkg::dp_status_t                   status,
    output logic                                   result_valid,
    output srsw_pkg::srsw_out_t                    result
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int OCC_W  = $clog2(MAX_WINDOW + 1);
    localparam int SEQ_W  = srsw_pkg::SEQ_W;
    localparam int FR_W   = srsw_pkg::FRAME_W;
    localparam int WS_W   = srsw_pkg::WIN_CFG_W;

    localparam logic [OCC_W:0]   DEPTH    = (OCC_W + 1)'(MAX_WINDOW);
    localparam logic [OCC_W:0]   OCC_ONE  = (OCC_W + 1)'(1);
    localparam logic [WS_W-1:0]  MAX_WS   = WS_W'(MAX_WINDOW);
    localparam logic [FR_W:0]    ISS_ONE  = (FR_W + 1)'(1);

    // slot at offset off from base, around the circular window
    function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] base,
                                                  input logic [OCC_W-1:0]  off);
        logic [OCC_W:0] sum;
        sum = (OCC_W + 1)'(base) + (OCC_W + 1)'(off);
        if (sum >= DEPTH)
        begin
            sum = sum - DEPTH;
        end
        return sum[SLOT_W-1:0];
    endfunction

    logic [WS_W-1:0]       win_size_reg;
    logic [FR_W-1:0]       total_reg;
    logic [SEQ_W-1:0]      ack_reg;

    logic [SEQ_W-1:0]      seq_mem_reg   [MAX_WINDOW];
    logic [FR_W-1:0]       frame_mem_reg [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] acked_reg;
    logic [MAX_WINDOW-1:0] acked_next;

    logic [SLOT_W-1:0]     head_reg;
    logic [SLOT_W-1:0]     head_next;
    logic [OCC_W-1:0]      occ_reg;
    logic [OCC_W-1:0]      occ_next;
    logic [OCC_W-1:0]      cnt_reg;
    logic [OCC_W-1:0]      cnt_next;
    logic [SEQ_W-1:0]      next_seq_reg;
    logic [SEQ_W-1:0]      next_seq_next;
    logic [FR_W-1:0]       issued_reg;
    logic [FR_W-1:0]       issued_next;
    logic [FR_W-1:0]       ack_cnt_reg;
    logic [FR_W-1:0]       ack_cnt_next;

    logic                  result_valid_reg;
    logic                  result_valid_next;
    srsw_pkg::srsw_out_t   result_reg;
    srsw_pkg::srsw_out_t   result_next;

    logic [OCC_W-1:0]      w_eff;
    logic [SEQ_W:0]        mod_val;
    logic [SEQ_W-1:0]      seq_inc;
    logic [SEQ_W-1:0]      seq_wrapped;
    logic [SLOT_W-1:0]     rd_slot;
    logic [SLOT_W-1:0]     tail_slot;
    logic [SEQ_W-1:0]      rd_seq;
    logic [FR_W-1:0]       rd_frame;
    logic                  rd_acked;
    logic                  can_load;
    logic                  issue_last;
    logic                  done_now;
    logic                  load_en;
    logic                  load_start;

    // a window size of zero acts as one, above the slot count it saturates
    always_comb
    begin
        if (win_size_reg == '0)
        begin
            w_eff = OCC_W'(1);
        end
        else if (win_size_reg > MAX_WS)
        begin
            w_eff = OCC_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = OCC_W'(win_size_reg);
        end
    end

    assign mod_val     = (SEQ_W + 1)'({w_eff, 1'b1});
    assign seq_inc     = next_seq_reg + SEQ_W'(1);
    assign seq_wrapped = ({1'b0, seq_inc} > mod_val) ? SEQ_W'(1) : seq_inc;

    assign rd_slot   = slot_at(head_reg, cnt_reg);
    assign tail_slot = slot_at(head_reg, occ_reg);
    assign rd_seq    = seq_mem_reg[rd_slot];
    assign rd_frame  = frame_mem_reg[rd_slot];
    assign rd_acked  = acked_reg[rd_slot];

    assign can_load   = (issued_reg < total_reg);
    assign issue_last = (({1'b0, issued_reg} + ISS_ONE) >= {1'b0, total_reg});
    assign done_now   = (ack_cnt_reg >= total_reg) && (occ_reg == '0);
    assign load_start = (cmd.op == srsw_pkg::CMD_LOAD_START);

    // cnt_reg is zero in the ack state, so rd_slot is the head there
    assign status.occ_zero    = (occ_reg == '0);
    assign status.head_match  = (rd_seq == ack_reg);
    assign status.head_acked  = acked_reg[head_reg];
    assign status.start_more  = can_load && (cnt_reg < w_eff);
    assign status.start_last  = issue_last ||
                                (({1'b0, cnt_reg} + OCC_ONE) >= {1'b0, w_eff});
    assign status.refill_more = can_load && (cnt_reg != '0);
    assign status.refill_last = issue_last || (cnt_reg == OCC_W'(1));
    assign status.walk_last   = (({1'b0, cnt_reg} + OCC_ONE) >= {1'b0, occ_reg});

    always_comb
    begin
        acked_next        = acked_reg;
        head_next         = head_reg;
        occ_next          = occ_reg;
        cnt_next          = cnt_reg;
        next_seq_next     = next_seq_reg;
        issued_next       = issued_reg;
        ack_cnt_next      = ack_cnt_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        load_en           = 1'b0;
        case (cmd.op)
            srsw_pkg::CMD_CLEAR:
            begin
                acked_next    = '0;
                head_next     = '0;
                occ_next      = '0;
                next_seq_next = SEQ_W'(1);
                issued_next   = '0;
                ack_cnt_next  = '0;
            end
            srsw_pkg::CMD_LOAD_START,
            srsw_pkg::CMD_LOAD_REFILL:
            begin
                load_en                 = 1'b1;
                acked_next[tail_slot]   = 1'b0;
                occ_next                = occ_reg + OCC_W'(1);
                issued_next             = issued_reg + FR_W'(1);
                next_seq_next           = seq_wrapped;
                cnt_next                = load_start ? (cnt_reg + OCC_W'(1))
                                                     : (cnt_reg - OCC_W'(1));
                result_valid_next       = 1'b1;
                result_next.has_frame   = 1'b1;
                result_next.send_seq    = next_seq_reg;
                result_next.send_frame  = issued_reg;
                result_next.last        = load_start ? status.start_last
                                                     : status.refill_last;
                result_next.done_res    = 1'b0;
            end
            srsw_pkg::CMD_HEAD_ACK,
            srsw_pkg::CMD_MARK:
            begin
                if ((rd_seq == ack_reg) && !rd_acked)
                begin
                    acked_next[rd_slot] = 1'b1;
                    ack_cnt_next        = ack_cnt_reg + FR_W'(1);
                end
                if (cmd.op == srsw_pkg::CMD_MARK)
                begin
                    cnt_next = cnt_reg + OCC_W'(1);
                end
            end
            srsw_pkg::CMD_POP:
            begin
                // cnt counts pops, later the refill budget
                acked_next[head_reg] = 1'b0;
                head_next            = slot_at(head_reg, OCC_W'(1));
                occ_next             = occ_reg - OCC_W'(1);
                cnt_next             = cnt_reg + OCC_W'(1);
            end
            srsw_pkg::CMD_RESEND:
            begin
                cnt_next               = cnt_reg + OCC_W'(1);
                result_valid_next      = 1'b1;
                result_next.has_frame  = 1'b1;
                result_next.send_seq   = rd_seq;
                result_next.send_frame = rd_frame;
                result_next.last       = status.walk_last;
                result_next.done_res   = 1'b0;
            end
            srsw_pkg::CMD_EMPTY:
            begin
                result_valid_next      = 1'b1;
                result_next.has_frame  = 1'b0;
                result_next.send_seq   = '0;
                result_next.send_frame = '0;
                result_next.last       = 1'b1;
                result_next.done_res   = done_now;
            end
            default:
            begin
            end
        endcase
        if (cmd.capture)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg     <= WS_W'(1);
            total_reg        <= FR_W'(1);
            acked_reg        <= '0;
            head_reg         <= '0;
            occ_reg          <= '0;
            cnt_reg          <= '0;
            next_seq_reg     <= SEQ_W'(1);
            issued_reg       <= '0;
            ack_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    srsw_pkg::REG_WINDOW_SIZE:  win_size_reg <= cfg_data[WS_W-1:0];
                    srsw_pkg::REG_TOTAL_FRAMES: total_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            acked_reg        <= acked_next;
            head_reg         <= head_next;
            occ_reg          <= occ_next;
            cnt_reg          <= cnt_next;
            next_seq_reg     <= next_seq_next;
            issued_reg       <= issued_next;
            ack_cnt_reg      <= ack_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ack_reg <= ack_seq;
        end
        if (load_en)
        begin
            seq_mem_reg[tail_slot]   <= next_seq_reg;
            frame_mem_reg[tail_slot] <= issued_reg;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/selective_repeat_sender_window_unit.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_unit
// sender side of a selective repeat window: start, ack and timeout items
// produce frame send orders from a circular window of frames in flight
// ----------------------------------------------------------------------------
//  channel   | signals                          | handshake
//  ----------+----------------------------------+----------------------------
//  item in   | start, busy, req                 | taken when start & !busy
//  result    | result_valid, result             | one-cycle strobe, no stall
//  config    | cfg_wr_en, cfg_index, cfg_data   | written when cfg_wr_en
//
//  start clears, then loads frames; an ack to the oldest frame marks it, pops
//  the acked front run, then refills; other acks scan the window; timeout
//  resends each frame; an empty window or unknown opcode gives an empty result.
//  the sequencer does one slot step a cycle; results are never held off.
//  each result shows in the cycle after its step; busy drops as the last shows.
//  async reset leaves an empty window, window_size 1 and total_frames 1.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_unit #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  srsw_pkg::srsw_in_t               req,
    output logic                             result_valid,
    output srsw_pkg::srsw_out_t              result,
    input  logic                             cfg_wr_en,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srsw_pkg::FRAME_W-1:0]     cfg_data
);

    srsw_pkg::dp_cmd_t    dp_cmd;
    srsw_pkg::dp_status_t dp_status;

    srsw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (req.opcode),
        .status (dp_status),
        .cmd    (dp_cmd),
        .busy   (busy)
    );

    srsw_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ack_seq      (req.ack_seq),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== design/srsw_checker.sv =====
// ----------------------------------------------------------------------------
// srsw_checker
// port-level checks on item acceptance and result framing
// ----------------------------------------------------------------------------
`include "selective_repeat_sender_window_unit_macros.svh"

module srsw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                result_valid,
    input srsw_pkg::srsw_out_t result
);

    `SRSW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item accepted but busy stayed low")
    `SRSW_ASSERT_SAME(a_last_idle, result_valid && result.last, !busy, "busy high on last result")
    `SRSW_ASSERT_SAME(a_res_after_busy, result_valid, $past(busy), "result without item in work")
    `SRSW_ASSERT_SAME(a_empty_last, result_valid && !result.has_frame, result.last && (result.send_seq == '0), "empty result not final or carries a sequence")
    `SRSW_ASSERT_SAME(a_done_no_frame, result_valid && result.done_res, !result.has_frame, "done flagged on a send order")

endmodule

bind selective_repeat_sender_window_unit srsw_checker u_srsw_checker (.*);
